// ===== rtl/core/bss_pkg.sv =====
package bss_pkg;

  // Default number of stack entries.
  localparam int unsigned BSS_DEPTH = 16;

  // Payload widths fixed by the interface.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned OCC_W    = 5;

  // Command codes carried by an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  // Status codes carried by a result transaction.
  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED      = 3'd0,
    ST_FULL        = 3'd1,
    ST_POPPED      = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_SEARCH_DONE = 3'd4
  } status_e;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/bss_ram.sv =====
module bss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one read port; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bounded_stack_with_search_core.sv =====
// Bounded LIFO stack of signed 32-bit words with a linear search.
// Input channel (in_valid_i / in_ready_o) carries cmd_i and value_i: push stores
// value_i on top, pop removes the top word, search looks for value_i among the
// occupied entries from the bottom up. Every input transaction yields exactly one
// result transaction on the output channel (out_valid_o / out_ready_i) with
// status, popped data, found flag, lowest matching position and occupancy.
// Push, unused commands, and pop or search on an empty stack go from acceptance
// straight to the done state, where the result waits for the output register;
// a pop first reads the top word from the stack memory; a search streams the
// occupied entries one per cycle through the single read port of the stack
// memory and compares each, stopping at the first match or the last entry.
// One command is processed at a time; a new one is taken once the previous
// result has been handed to the output register.
// If the receiver stalls, the result waits in the output register; the next
// command is still accepted and processed, and its result waits for the slot.
// Reset empties the stack and clears all handshake state; memory contents are
// not cleared, since only data read from written entries is ever used.
module bounded_stack_with_search_core
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = BSS_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic signed [WORD_W-1:0]   value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [WORD_W-1:0]   data_o,
  output logic                       found_o,
  output logic [POS_W-1:0]           position_o,
  output logic [OCC_W-1:0]           occupancy_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  state_e state_q, state_d;

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic [CW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [WORD_W-1:0]   key_q, key_d;

  // Result waiting in the sequencer.
  status_e             res_status_q, res_status_d;
  logic [WORD_W-1:0]   res_data_q, res_data_d;
  logic                res_found_q, res_found_d;
  logic [POS_W-1:0]    res_pos_q, res_pos_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [WORD_W-1:0]   out_data_q;
  logic                out_found_q;
  logic [POS_W-1:0]    out_pos_q;
  logic [OCC_W-1:0]    out_occ_q;

  logic                in_fire;
  logic                out_free;
  logic                load_out;
  cmd_e                cmd;
  logic                scan_hit;
  logic                scan_last;
  logic                scan_issue;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  assign cmd        = cmd_e'(cmd_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == S_DONE) && out_free;

  // Scan pipeline: one read issued and one entry compared per cycle.
  assign scan_issue = (rd_idx_q < count_q);
  assign scan_hit   = cmp_vld_q && (ram_rdata == key_q);
  assign scan_last  = cmp_vld_q && (cmp_idx_q == count_q - CW'(1));

  // Memory port control: a push writes at the top, a pop reads just below it.
  assign ram_we    = in_fire && (cmd == CMD_PUSH) && (count_q < FullCount);
  assign ram_waddr = count_q[AW-1:0];
  always_comb begin
    if (in_fire) begin
      ram_raddr = AW'(count_q - CW'(1));
    end else begin
      ram_raddr = rd_idx_q[AW-1:0];
    end
  end

  bss_ram #(
    .Width (WORD_W),
    .Depth (DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_POP && count_q != '0) begin
            state_d = S_POP_RD;
          end else if (cmd == CMD_SEARCH && count_q != '0) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_POP_RD: begin
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and result updates for each state.
  always_comb begin
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = 1'b0;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_found_d  = res_found_q;
    res_pos_d    = res_pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_SEARCH_DONE;
          res_data_d   = '0;
          res_found_d  = 1'b0;
          res_pos_d    = '0;
          key_d        = value_i;
          rd_idx_d     = '0;
          unique case (cmd)
            CMD_PUSH: begin
              if (count_q < FullCount) begin
                count_d      = count_q + CW'(1);
                res_status_d = ST_PUSHED;
              end else begin
                res_status_d = ST_FULL;
              end
            end
            CMD_POP: begin
              if (count_q != '0) begin
                count_d      = count_q - CW'(1);
                res_status_d = ST_POPPED;
              end else begin
                res_status_d = ST_EMPTY;
              end
            end
            CMD_SEARCH: begin
              res_status_d = ST_SEARCH_DONE;
            end
            default: begin
              res_status_d = ST_SEARCH_DONE;
            end
          endcase
        end
      end
      S_POP_RD: begin
        res_data_d = ram_rdata;
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_found_d = 1'b1;
          res_pos_d   = POS_W'(cmp_idx_q);
        end else if (!scan_last && scan_issue) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q;
          rd_idx_d  = rd_idx_q + CW'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_found_q  <= res_found_d;
    res_pos_q    <= res_pos_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_found_q  <= res_found_q;
      out_pos_q    <= res_pos_q;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_o      = out_data_q;
  assign found_o     = out_found_q;
  assign position_o  = out_pos_q;
  assign occupancy_o = out_occ_q;

endmodule
